[rtl/color_palette_access_port_defines.svh]
// Assertion macros shared by the palette port RTL
`ifndef COLOR_PALETTE_ACCESS_PORT_DEFINES_SVH
`define COLOR_PALETTE_ACCESS_PORT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define CPAP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define CPAP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/cpap_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cpap_pkg;

   // Palette geometry
   localparam int PALETTE_BYTES_DEF = 64;
   localparam int INDEX_ENTRIES     = 64;

   // Index register bits
   localparam int IDX_FORCED_BIT  = 6;
   localparam int IDX_AUTOINC_BIT = 7;

   // Fixed read values
   localparam logic [7:0] OPEN_BUS_BYTE = 8'hFF;
   localparam logic [7:0] WRITE_BYTE    = 8'h00;

   // Access commands
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Port codes
   localparam logic [1:0] PORT_BG_INDEX  = 2'd0;
   localparam logic [1:0] PORT_BG_DATA   = 2'd1;
   localparam logic [1:0] PORT_OBJ_INDEX = 2'd2;
   localparam logic [1:0] PORT_OBJ_DATA  = 2'd3;

   // Response source select
   localparam logic [1:0] SEL_BYTE    = 2'd0;
   localparam logic [1:0] SEL_MEM_BG  = 2'd1;
   localparam logic [1:0] SEL_MEM_OBJ = 2'd2;

   // Per-bank operation issued by the top level
   typedef struct packed {
      logic       idx_wr;
      logic       mem_wr;
      logic       rd_en;
      logic [7:0] wdata;
   } bank_op_type;

endpackage

`default_nettype wire

[rtl/cpap_bank.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "color_palette_access_port_defines.svh"

module cpap_bank #(
   parameter int PALETTE_BYTES = cpap_pkg::PALETTE_BYTES_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cpap_pkg::bank_op_type op,
   output logic [7:0]                index_q,
   output logic [7:0]                rd_data
);

   localparam int AW = (PALETTE_BYTES > 1) ? $clog2(PALETTE_BYTES) : 1;

   logic [7:0]              index_ff;
   logic [7:0]              index_in;
   logic [7:0]              mem [PALETTE_BYTES];
   logic [PALETTE_BYTES-1:0] vbit_ff;
   logic [7:0]              rd_ff;
   logic                    rdv_ff;
   logic [AW-1:0]           entry_tbl [cpap_pkg::INDEX_ENTRIES];
   logic [AW-1:0]           entry;

   // Map index bits 5..0 onto a palette entry
   for (genvar g = 0; g < cpap_pkg::INDEX_ENTRIES; g++) begin : g_entry
      assign entry_tbl[g] = AW'(g % PALETTE_BYTES);
   end

   assign entry = entry_tbl[index_ff[5:0]];

   // Index: load with bit 6 forced, advance after a data write when auto-increment is set
   always_comb begin
      index_in = index_ff;
      if (op.idx_wr) begin
         index_in = op.wdata;
         index_in[cpap_pkg::IDX_FORCED_BIT] = 1'b1;
      end else if (op.mem_wr && index_ff[cpap_pkg::IDX_AUTOINC_BIT]) begin
         index_in = {index_ff[7], 1'b1, index_ff[5:0] + 6'd1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
      end else begin
         index_ff <= index_in;
      end
   end

   // Entry valid bits stand in for the all-zero reset of the memory
   always_ff @(posedge clock) begin
      if (reset) begin
         vbit_ff <= '0;
      end else if (op.mem_wr) begin
         vbit_ff[entry] <= 1'b1;
      end
   end

   // Palette memory: one write or one registered read per beat
   always_ff @(posedge clock) begin
      if (op.mem_wr) begin
         mem[entry] <= op.wdata;
      end
      if (op.rd_en) begin
         rd_ff  <= mem[entry];
         rdv_ff <= vbit_ff[entry];
      end
   end

   assign index_q = index_ff;
   assign rd_data = rdv_ff ? rd_ff : 8'h00;

   `CPAP_ASSERT_NEXT(a_idx_forced, op.idx_wr, index_ff[cpap_pkg::IDX_FORCED_BIT], "index bit 6 not set after index write")
   `CPAP_ASSERT_NEXT(a_autoinc_keep, op.mem_wr && index_ff[cpap_pkg::IDX_AUTOINC_BIT] && !op.idx_wr, index_ff[7:6] == 2'b11, "auto-increment lost bits 7..6")
   `CPAP_ASSERT_NOW(a_one_op, 1'b1, !(op.mem_wr && op.rd_en) && !(op.mem_wr && op.idx_wr), "conflicting bank operations")

endmodule

`default_nettype wire

[rtl/color_palette_access_port.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "color_palette_access_port_defines.svh"

// Color palette access port: background and object palettes, each reached
// through an index port and a data port.
// Request channel (req_*): one access per beat, valid/stall; the port drives
// req_stall. Response channel (rsp_*): one read byte per request, in order;
// the downstream side drives rsp_stall. Writes return zero.
// Path: an accepted request is captured in the input register, then the
// memory read and response byte are registered into the response register;
// a receiver stall can hold either step.
// Throughput: one request per cycle while the receiver does not stall; the
// single palette memory port per bank takes the one read or write of each
// beat, and index updates finish in the same beat so the next request sees them.
// CSR channel (csr_*): writes color_mode_enabled; always ready; write only
// while no request is in flight.
// Reset: indexes clear, palettes read as zero, color mode comes up enabled,
// both pipeline stages empty.
// Receiver stall: the response register holds; the input register fills and
// then req_stall rises until the response is taken.
module color_palette_access_port #(
   parameter int PALETTE_BYTES = cpap_pkg::PALETTE_BYTES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_command,
   input  wire logic [1:0] req_port,
   input  wire logic [7:0] req_write_data,
   input  wire logic       req_lcd_busy,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_read_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_write_data
);

   logic       enable_ff;
   logic       s1_vld_ff, s1_vld_in;
   logic       s1_cmd_ff;
   logic [1:0] s1_port_ff;
   logic [7:0] s1_data_ff;
   logic       s1_busy_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_sel_ff, rsp_sel_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       req_fire, out_free, s1_adv;
   logic       is_obj, is_data, mem_ok;
   logic [7:0] bg_index, obj_index, bg_rd, obj_rd, cur_index;
   cpap_pkg::bank_op_type bg_op, obj_op;

   // Config register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         enable_ff <= csr_write_data;
      end
   end

   // Handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_vld_ff && out_free;
   assign req_stall = s1_vld_ff && !out_free;
   assign req_fire  = req_valid && !req_stall;

   assign s1_vld_in    = req_fire || (s1_vld_ff && !out_free);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_vld_ff    <= s1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register: capture the beat
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff  <= req_command;
         s1_port_ff <= req_port;
         s1_data_ff <= req_write_data;
         s1_busy_ff <= req_lcd_busy;
      end
   end

   // Decode the port
   always_comb begin
      is_obj  = 1'b0;
      is_data = 1'b0;
      unique case (s1_port_ff)
         cpap_pkg::PORT_BG_INDEX:  begin is_obj = 1'b0; is_data = 1'b0; end
         cpap_pkg::PORT_BG_DATA:   begin is_obj = 1'b0; is_data = 1'b1; end
         cpap_pkg::PORT_OBJ_INDEX: begin is_obj = 1'b1; is_data = 1'b0; end
         cpap_pkg::PORT_OBJ_DATA:  begin is_obj = 1'b1; is_data = 1'b1; end
         default:                  begin is_obj = 1'b0; is_data = 1'b0; end
      endcase
   end

   assign mem_ok    = s1_adv && enable_ff && is_data && !s1_busy_ff;
   assign cur_index = is_obj ? obj_index : bg_index;

   // Issue bank operations
   always_comb begin
      bg_op.wdata  = s1_data_ff;
      obj_op.wdata = s1_data_ff;
      bg_op.idx_wr  = s1_adv && enable_ff && (s1_cmd_ff == cpap_pkg::CMD_WRITE)
                      && !is_data && !is_obj;
      obj_op.idx_wr = s1_adv && enable_ff && (s1_cmd_ff == cpap_pkg::CMD_WRITE)
                      && !is_data && is_obj;
      bg_op.mem_wr  = mem_ok && (s1_cmd_ff == cpap_pkg::CMD_WRITE) && !is_obj;
      obj_op.mem_wr = mem_ok && (s1_cmd_ff == cpap_pkg::CMD_WRITE) && is_obj;
      bg_op.rd_en   = mem_ok && (s1_cmd_ff == cpap_pkg::CMD_READ) && !is_obj;
      obj_op.rd_en  = mem_ok && (s1_cmd_ff == cpap_pkg::CMD_READ) && is_obj;
   end

   // Pick the response source
   always_comb begin
      rsp_sel_in  = cpap_pkg::SEL_BYTE;
      rsp_byte_in = cpap_pkg::WRITE_BYTE;
      if (s1_cmd_ff == cpap_pkg::CMD_READ) begin
         if (!enable_ff) begin
            rsp_byte_in = cpap_pkg::OPEN_BUS_BYTE;
         end else if (!is_data) begin
            rsp_byte_in = cur_index;
         end else if (s1_busy_ff) begin
            rsp_byte_in = cpap_pkg::OPEN_BUS_BYTE;
         end else begin
            rsp_sel_in = is_obj ? cpap_pkg::SEL_MEM_OBJ : cpap_pkg::SEL_MEM_BG;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_sel_ff  <= rsp_sel_in;
         rsp_byte_ff <= rsp_byte_in;
      end
   end

   cpap_bank #(.PALETTE_BYTES(PALETTE_BYTES)) u_bg (
      .clock   (clock),
      .reset   (reset),
      .op      (bg_op),
      .index_q (bg_index),
      .rd_data (bg_rd)
   );

   cpap_bank #(.PALETTE_BYTES(PALETTE_BYTES)) u_obj (
      .clock   (clock),
      .reset   (reset),
      .op      (obj_op),
      .index_q (obj_index),
      .rd_data (obj_rd)
   );

   // Output mux
   always_comb begin
      case (rsp_sel_ff)
         cpap_pkg::SEL_MEM_BG:  rsp_read_data = bg_rd;
         cpap_pkg::SEL_MEM_OBJ: rsp_read_data = obj_rd;
         default:               rsp_read_data = rsp_byte_ff;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `CPAP_ASSERT_NEXT(a_adv_valid, s1_adv, rsp_valid_ff, "advanced beat did not reach response register")
   `CPAP_ASSERT_NOW(a_disabled_quiet, s1_adv && !enable_ff, !(bg_op.idx_wr || bg_op.mem_wr || obj_op.idx_wr || obj_op.mem_wr), "write issued with color mode off")
   `CPAP_ASSERT_NOW(a_single_op, 1'b1, $onehot0({bg_op.idx_wr, bg_op.mem_wr, bg_op.rd_en, obj_op.idx_wr, obj_op.mem_wr, obj_op.rd_en}), "more than one bank operation in a beat")

endmodule

`default_nettype wire
